/* design/ttc_pkg.sv */
// ---------------------------------------------------------------------------
// ttc_pkg
// Shared constants, codes and types for the text console cursor engine.
// ---------------------------------------------------------------------------
package ttc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_BRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z   = 8'h7A;

    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_SKIP   = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SCROLL = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] glyph;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ATTR_W-1:0] attr;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

/* design/ttc_cursor_core.sv */
// ---------------------------------------------------------------------------
// ttc_cursor_core
// Cursor and escape state; decodes one character into up to two results.
// ---------------------------------------------------------------------------
module ttc_cursor_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [ttc_pkg::CHAR_W-1:0]    char_in,
    input  logic [ttc_pkg::ATTR_W-1:0]    attribute,
    output ttc_pkg::push_t                push
);
    import ttc_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    mode_t            mode_reg, mode_next;

    logic [COL_W-1:0] col_step;
    logic [ROW_W-1:0] row_step;
    logic             wr, sc;
    result_t          wr_res, sc_res;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        mode_next = mode_reg;
        col_step = col_reg;
        row_step = row_reg;
        wr = 1'b0;
        sc = 1'b0;

        if (char_in != CH_NUL)
        begin
            unique case (mode_reg)
                MODE_SKIP:
                begin
                    if (char_in > CH_LOW_A && char_in < CH_LOW_Z)
                        mode_next = MODE_NORMAL;
                end
                MODE_ESC:
                begin
                    mode_next = (char_in == CH_BRACKET) ? MODE_SKIP : MODE_NORMAL;
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (char_in == CH_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        if (char_in == CH_NL)
                        begin
                            row_step = row_reg + 1'b1;
                            col_step = '0;
                        end
                        else
                        begin
                            wr = 1'b1;
                            col_step = col_reg + 1'b1;
                            if (col_step >= COL_LIMIT)
                            begin
                                col_step = '0;
                                row_step = row_reg + 1'b1;
                            end
                        end
                        if (row_step >= ROW_LIMIT)
                        begin
                            sc = 1'b1;
                            row_step = ROW_LAST;
                            col_step = '0;
                        end
                        col_next = col_step;
                        row_next = row_step;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        wr_res.kind = KIND_WRITE;
        wr_res.glyph = char_in;
        wr_res.col = col_reg;
        wr_res.row = row_reg;
        wr_res.attr = attribute;
        wr_res.last = !sc;

        sc_res.kind = KIND_SCROLL;
        sc_res.glyph = '0;
        sc_res.col = '0;
        sc_res.row = ROW_LAST;
        sc_res.attr = attribute;
        sc_res.last = 1'b1;

        push.res0 = wr ? wr_res : sc_res;
        push.res1 = sc_res;
        push.count = fire ? ({1'b0, wr} + {1'b0, sc}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            mode_reg <= MODE_NORMAL;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            mode_reg <= mode_next;
        end
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_LIMIT && row_reg < ROW_LIMIT)
        else $error("cursor outside screen");

    a_scroll_homes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && sc |=> row_reg == ROW_LAST && col_reg == '0)
        else $error("scroll did not home cursor to bottom row");

    a_pair_is_write_then_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.res0.kind == KIND_WRITE
                             && push.res1.kind == KIND_SCROLL && !push.res0.last)
        else $error("bad result pair");

endmodule

/* design/ttc_result_fifo.sv */
// ---------------------------------------------------------------------------
// ttc_result_fifo
// Small result queue; takes up to two results a cycle, sends one a cycle unless out_stall holds it.
// ---------------------------------------------------------------------------
module ttc_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  ttc_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output ttc_pkg::result_t  head
);
    import ttc_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0] wptr_inc;
    logic               pop;

    assign out_valid = count_reg != '0;
    assign head = mem_reg[rptr_reg];
    assign pop = out_valid && !out_stall;
    assign room = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign wptr_inc = wptr_reg + 1'b1;

    always_comb
    begin
        wptr_next = wptr_reg + FIFO_AW'(push.count);
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wptr_reg] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[wptr_inc] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("push into full result queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result count out of range");

    a_pop_only_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count slip on pop");

endmodule

/* design/text_console_cursor_engine.sv */
// Path: a taken character waits in char_reg, then is decoded into the result queue.
// Throughput: one character per cycle while the queue has room; a character that writes
// and scrolls gives two results, so output (one result a cycle, unless stalled) sets the rate.
// Reset: cursor at column 0, row 0, normal mode, attribute 0x07, no results pending.
// ---------------------------------------------------------------------------
// text_console_cursor_engine
// Character stream to cell-write and scroll requests with escape skipping.
// ---------------------------------------------------------------------------
module text_console_cursor_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ttc_pkg::CHAR_W-1:0]    char_in,
    input  logic                          cfg_we,
    input  logic [ttc_pkg::ATTR_W-1:0]    cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [ttc_pkg::CHAR_W-1:0]    glyph,
    output logic [ttc_pkg::COL_W-1:0]     cell_col,
    output logic [ttc_pkg::ROW_W-1:0]     cell_row,
    output logic [ttc_pkg::ATTR_W-1:0]    cell_attr,
    output logic                          last
);
    import ttc_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic              room;
    logic              fire;
    logic              in_take;
    push_t             push;
    result_t           head;

    assign fire = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
                attr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            char_reg <= char_in;
    end

    ttc_cursor_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_in   (char_reg),
        .attribute (attr_reg),
        .push      (push)
    );

    ttc_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind = head.kind;
    assign glyph = head.glyph;
    assign cell_col = head.col;
    assign cell_row = head.row;
    assign cell_attr = head.attr;
    assign last = head.last;

endmodule
